// ===== sv/hlcs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hlcs_pkg
// Shared types and constants of the Hough line cluster suppression block.
// ----------------------------------------------------------------------------
package hlcs_pkg;

    localparam int RHO_W   = 15;
    localparam int THETA_W = 16;
    localparam int VOTES_W = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RHO_TOL   = 2'd0,
        CFG_THETA_TOL = 2'd1,
        CFG_MODE      = 2'd2,
        CFG_TARGET    = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        CMD_ADD   = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_t;

    // One request as it travels from the front queue to the engine.
    typedef struct packed {
        logic                       cmd;
        logic signed [RHO_W-1:0]    rho;
        logic        [THETA_W-1:0]  theta;
        logic        [VOTES_W-1:0]  votes;
    } req_t;

    // One result.
    typedef struct packed {
        logic signed [RHO_W-1:0]    rho;
        logic        [THETA_W-1:0]  theta;
        logic        [VOTES_W-1:0]  votes;
        logic                       last;
        logic                       empty_res;
        logic                       overflow;
    } res_t;

endpackage : hlcs_pkg
`default_nettype wire

// ===== sv/hough_line_cluster_suppress.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hough_line_cluster_suppress
// Greedy clustering of Hough lines with one kept line per cluster.
// ----------------------------------------------------------------------------
// An add request reads and compares each stored cluster in turn (S_READ,
// S_CMP); when it joins a cluster, two bit-serial divisions for the new
// means (S_DIVR, S_DIVT, one quotient bit a cycle) precede the write-back,
// and when it opens one, only the write-back. A flush reads and outputs each
// result (S_FRD, S_FOUT). Requests and results each wait in a 4-entry queue,
// so both sides stall independently. Configuration writes take effect at once.
module hough_line_cluster_suppress #(
    parameter int MAX_CLUSTERS = 32,
    parameter int MAX_MEMBERS  = 1024
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [hlcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [hlcs_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic                              command,
    input  wire logic signed [hlcs_pkg::RHO_W-1:0] line_rho,
    input  wire logic [hlcs_pkg::THETA_W-1:0]      line_theta,
    input  wire logic [hlcs_pkg::VOTES_W-1:0]      line_votes,
    output logic                                   empty,
    input  wire logic                              pop,
    output logic signed [hlcs_pkg::RHO_W-1:0]      rep_rho,
    output logic [hlcs_pkg::THETA_W-1:0]           rep_theta,
    output logic [hlcs_pkg::VOTES_W-1:0]           rep_votes,
    output logic                                   last,
    output logic                                   empty_res,
    output logic                                   overflow
);
    import hlcs_pkg::*;

    logic [RHO_W-1:0]   rho_tol_reg;
    logic [THETA_W-1:0] theta_tol_reg;
    logic               mode_reg;
    logic [THETA_W-1:0] target_reg;

    req_t in_req, q_req;
    res_t e_res, o_res;
    logic q_empty, q_pop, r_push, r_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rho_tol_reg   <= RHO_W'(80);
            theta_tol_reg <= THETA_W'(2048);
            mode_reg      <= 1'b0;
            target_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_RHO_TOL:   rho_tol_reg   <= cfg_data[RHO_W-1:0];
                CFG_THETA_TOL: theta_tol_reg <= cfg_data;
                CFG_MODE:      mode_reg      <= cfg_data[0];
                CFG_TARGET:    target_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign in_req = '{cmd: command, rho: line_rho, theta: line_theta, votes: line_votes};

    hlcs_fifo #(
        .WIDTH ($bits(req_t)),
        .DEPTH (4)
    ) u_req_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (in_req),
        .full  (full),
        .pop   (q_pop),
        .rdata (q_req),
        .empty (q_empty)
    );

    hlcs_engine #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_MEMBERS  (MAX_MEMBERS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (!q_empty),
        .req       (q_req),
        .req_pop   (q_pop),
        .rho_tol   (rho_tol_reg),
        .theta_tol (theta_tol_reg),
        .mode      (mode_reg),
        .target    (target_reg),
        .res_push  (r_push),
        .res       (e_res),
        .res_full  (r_full)
    );

    hlcs_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (4)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (r_push),
        .wdata (e_res),
        .full  (r_full),
        .pop   (pop),
        .rdata (o_res),
        .empty (empty)
    );

    assign rep_rho   = o_res.rho;
    assign rep_theta = o_res.theta;
    assign rep_votes = o_res.votes;
    assign last      = o_res.last;
    assign empty_res = o_res.empty_res;
    assign overflow  = o_res.overflow;

endmodule : hough_line_cluster_suppress
`default_nettype wire

// ===== sv/hlcs_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hlcs_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module hlcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wp_reg, wp_next, rp_reg, rp_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wp_next = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (do_pop)
        begin
            rp_next = (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule : hlcs_fifo
`default_nettype wire

// ===== sv/hlcs_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hlcs_div
// Restoring divider, one quotient bit a cycle. Signed dividend, unsigned
// divisor, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module hlcs_div #(
    parameter int NW = 26,
    parameter int DW = 11
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [NW-1:0] num,
    input  wire logic        [DW-1:0] den,
    output logic                      busy,
    output logic signed [NW-1:0]      quo
);
    localparam int SW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [SW-1:0] step_reg, step_next;
    logic          neg_reg, neg_next;
    logic          busy_reg, busy_next;
    logic [DW+1:0] trial;

    assign busy = busy_reg;
    assign quo  = neg_reg ? -$signed(q_reg) : $signed(q_reg);
    assign trial = {r_reg, q_reg[NW-1]} - {2'b00, den};

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        if (start)
        begin
            neg_next  = num[NW-1];
            q_next    = num[NW-1] ? NW'(-num) : NW'(num);
            r_next    = '0;
            step_next = SW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DW+1])
            begin
                r_next = trial[DW:0];
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[DW-1:0], q_reg[NW-1]};
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == SW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        neg_reg <= neg_next;
    end

endmodule : hlcs_div
`default_nettype wire

// ===== sv/hlcs_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hlcs_engine
// Back end: scans the cluster table, updates sums, means and the kept line,
// and walks the table on flush.
// ----------------------------------------------------------------------------
module hlcs_engine #(
    parameter int MAX_CLUSTERS = 32,
    parameter int MAX_MEMBERS  = 1024
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    input  wire hlcs_pkg::req_t              req,
    output logic                             req_pop,
    input  wire logic [hlcs_pkg::RHO_W-1:0]  rho_tol,
    input  wire logic [hlcs_pkg::THETA_W-1:0] theta_tol,
    input  wire logic                        mode,
    input  wire logic [hlcs_pkg::THETA_W-1:0] target,
    output logic                             res_push,
    output hlcs_pkg::res_t                   res,
    input  wire logic                        res_full
);
    import hlcs_pkg::*;

    localparam int IW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CW  = $clog2(MAX_CLUSTERS + 1);
    localparam int MW  = $clog2(MAX_MEMBERS + 1);
    localparam int SRW = RHO_W + MW;
    localparam int STW = THETA_W + MW + 1;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_READ  = 8'b0000_0010,
        S_CMP   = 8'b0000_0100,
        S_DIVR  = 8'b0000_1000,
        S_DIVT  = 8'b0001_0000,
        S_WRITE = 8'b0010_0000,
        S_FRD   = 8'b0100_0000,
        S_FOUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Cluster table, one entry a row.
    logic signed [SRW-1:0]   sr_mem [MAX_CLUSTERS];
    logic signed [STW-1:0]   st_mem [MAX_CLUSTERS];
    logic [MW-1:0]           mc_mem [MAX_CLUSTERS];
    logic signed [RHO_W-1:0] mr_mem [MAX_CLUSTERS];
    logic [THETA_W-1:0]      mt_mem [MAX_CLUSTERS];
    logic signed [RHO_W-1:0] br_mem [MAX_CLUSTERS];
    logic [THETA_W-1:0]      bt_mem [MAX_CLUSTERS];
    logic [VOTES_W-1:0]      bv_mem [MAX_CLUSTERS];

    logic signed [SRW-1:0]   sr_q;
    logic signed [STW-1:0]   st_q;
    logic [MW-1:0]           mc_q;
    logic signed [RHO_W-1:0] mr_q;
    logic [THETA_W-1:0]      mt_q;
    logic signed [RHO_W-1:0] br_q;
    logic [THETA_W-1:0]      bt_q;
    logic [VOTES_W-1:0]      bv_q;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          drop_reg, drop_next;
    logic [IW-1:0] rd_addr;

    // Write-back values.
    logic signed [SRW-1:0]   nsr_reg, nsr_next;
    logic signed [STW-1:0]   nst_reg, nst_next;
    logic [MW-1:0]           nmc_reg, nmc_next;
    logic signed [RHO_W-1:0] nmr_reg, nmr_next;
    logic [THETA_W-1:0]      nmt_reg, nmt_next;
    logic signed [RHO_W-1:0] nbr_reg, nbr_next;
    logic [THETA_W-1:0]      nbt_reg, nbt_next;
    logic [VOTES_W-1:0]      nbv_reg, nbv_next;
    logic [IW-1:0]           waddr_reg, waddr_next;
    logic                    we;

    logic                    div_start;
    logic signed [STW-1:0]   div_num;
    logic                    div_busy;
    logic signed [STW-1:0]   div_quo;

    logic [RHO_W:0]          drho;
    logic [THETA_W-1:0]      dtheta, dnew, dold;
    logic                    hit, better;
    logic signed [RHO_W:0]   rho_x, mr_x;

    assign rd_addr = idx_next[IW-1:0];

    always_ff @(posedge clk)
    begin
        sr_q <= sr_mem[rd_addr];
        st_q <= st_mem[rd_addr];
        mc_q <= mc_mem[rd_addr];
        mr_q <= mr_mem[rd_addr];
        mt_q <= mt_mem[rd_addr];
        br_q <= br_mem[rd_addr];
        bt_q <= bt_mem[rd_addr];
        bv_q <= bv_mem[rd_addr];
        if (we)
        begin
            sr_mem[waddr_reg] <= nsr_reg;
            st_mem[waddr_reg] <= nst_reg;
            mc_mem[waddr_reg] <= nmc_reg;
            mr_mem[waddr_reg] <= nmr_reg;
            mt_mem[waddr_reg] <= nmt_reg;
            br_mem[waddr_reg] <= nbr_reg;
            bt_mem[waddr_reg] <= nbt_reg;
            bv_mem[waddr_reg] <= nbv_reg;
        end
    end

    hlcs_div #(
        .NW (STW),
        .DW (MW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (nmc_reg),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    assign rho_x  = {req.rho[RHO_W-1], req.rho};
    assign mr_x   = {mr_q[RHO_W-1], mr_q};
    assign drho   = (rho_x > mr_x) ? (RHO_W+1)'(rho_x - mr_x) : (RHO_W+1)'(mr_x - rho_x);
    assign dtheta = (req.theta > mt_q) ? req.theta - mt_q : mt_q - req.theta;
    assign hit    = (drho < {1'b0, rho_tol}) && (dtheta < theta_tol);
    assign dnew   = (req.theta > target) ? req.theta - target : target - req.theta;
    assign dold   = (bt_q > target) ? bt_q - target : target - bt_q;
    assign better = mode ? (dnew < dold) : (req.votes > bv_q);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        drop_next  = drop_reg;
        nsr_next   = nsr_reg;
        nst_next   = nst_reg;
        nmc_next   = nmc_reg;
        nmr_next   = nmr_reg;
        nmt_next   = nmt_reg;
        nbr_next   = nbr_reg;
        nbt_next   = nbt_reg;
        nbv_next   = nbv_reg;
        waddr_next = waddr_reg;
        we         = 1'b0;
        req_pop    = 1'b0;
        res_push   = 1'b0;
        div_start  = 1'b0;
        div_num    = STW'(nsr_reg);
        res        = '0;
        res.overflow = drop_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (req_valid)
                begin
                    state_next = (req.cmd == CMD_FLUSH) ? S_FRD : S_READ;
                end
            end
            S_READ:
            begin
                // Read data for idx_reg lands this cycle.
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (idx_reg == count_reg)
                begin
                    req_pop = 1'b1;
                    state_next = S_IDLE;
                    if (count_reg == CW'(MAX_CLUSTERS))
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        // Open a new cluster.
                        waddr_next = idx_reg[IW-1:0];
                        nsr_next = SRW'(req.rho);
                        nst_next = STW'({1'b0, req.theta});
                        nmc_next = MW'(1);
                        nmr_next = req.rho;
                        nmt_next = req.theta;
                        nbr_next = req.rho;
                        nbt_next = req.theta;
                        nbv_next = req.votes;
                        count_next = count_reg + 1'b1;
                        state_next = S_WRITE;
                    end
                end
                else if (hit)
                begin
                    if (mc_q >= MW'(MAX_MEMBERS))
                    begin
                        drop_next = 1'b1;
                        req_pop = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        waddr_next = idx_reg[IW-1:0];
                        nmc_next = mc_q + 1'b1;
                        nsr_next = sr_q + SRW'(req.rho);
                        nst_next = st_q + STW'({1'b0, req.theta});
                        nbr_next = better ? req.rho : br_q;
                        nbt_next = better ? req.theta : bt_q;
                        nbv_next = better ? req.votes : bv_q;
                        state_next = S_DIVR;
                        idx_next = CW'(0);
                        div_start = 1'b0;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_DIVR:
            begin
                // First cycle starts the rho division; wait for it.
                if (idx_reg == '0)
                begin
                    div_num   = STW'(nsr_reg);
                    div_start = 1'b1;
                    idx_next  = CW'(1);
                end
                else if (!div_busy)
                begin
                    nmr_next  = RHO_W'(div_quo);
                    div_num   = nst_reg;
                    div_start = 1'b1;
                    state_next = S_DIVT;
                end
            end
            S_DIVT:
            begin
                if (!div_busy)
                begin
                    nmt_next = THETA_W'(div_quo);
                    req_pop = 1'b1;
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                we = 1'b1;
                idx_next = '0;
                state_next = S_IDLE;
            end
            S_FRD:
            begin
                state_next = S_FOUT;
            end
            S_FOUT:
            begin
                if (count_reg == '0)
                begin
                    res.last = 1'b1;
                    res.empty_res = 1'b1;
                end
                else
                begin
                    res.rho   = br_q;
                    res.theta = bt_q;
                    res.votes = bv_q;
                    res.last  = (idx_reg + 1'b1 == count_reg);
                end
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (count_reg == '0 || res.last)
                    begin
                        req_pop = 1'b1;
                        count_next = '0;
                        drop_next = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        state_next = S_FRD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nsr_reg   <= nsr_next;
        nst_reg   <= nst_next;
        nmc_reg   <= nmc_next;
        nmr_reg   <= nmr_next;
        nmt_reg   <= nmt_next;
        nbr_reg   <= nbr_next;
        nbt_reg   <= nbt_next;
        nbv_reg   <= nbv_next;
        waddr_reg <= waddr_next;
    end

endmodule : hlcs_engine
`default_nettype wire
